// ===== rtl/s2ll_pkg.sv =====
// Shared constants, types and register codes for the sphere to lat-long remap address block.
`default_nettype none

package s2ll_pkg;

  // Number formats
  localparam int COORD_BITS     = 12;
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  // Field and register widths
  localparam int IDX_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Q30 polynomial datapath
  localparam int QW       = 31;
  localparam int HORNER_N = 5;
  localparam int SIN_W    = TRIG_FRAC_BITS + 2;
  localparam int MAG_W    = TRIG_FRAC_BITS + 1;

  // Products and coordinate placement
  localparam int PROD_W     = 2 * TRIG_FRAC_BITS + 2;
  localparam int PROD_SHIFT = 2 * TRIG_FRAC_BITS + 1;
  localparam int PE_W       = PROD_W + SIZE_W + 1;
  localparam int NW         = PE_W + 1;
  localparam int V_W        = NW - 1 - PROD_SHIFT;

  // Pipeline layout
  localparam int SIN_STAGES  = HORNER_N + 3;
  localparam int ST_PROD     = SIN_STAGES + 1;
  localparam int ST_SCALE    = SIN_STAGES + 2;
  localparam int ST_OUT      = SIN_STAGES + 3;
  localparam int PIPE_STAGES = SIN_STAGES + 4;

  localparam logic [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-2:0] QUARTER_R = (ANGLE_BITS - 1)'(1) << (ANGLE_BITS - 2);

  localparam logic [QW-1:0] ACC_INIT = QW'(3864);
  localparam logic [QW-1:0] HORNER_C [HORNER_N] = '{
    QW'(172272), QW'(5026996), QW'(85569306), QW'(693598668), QW'(1686629713)
  };
  localparam logic [QW+1:0] ROUND_ADD = (QW + 2)'(1) << (29 - TRIG_FRAC_BITS);
  localparam logic [MAG_W+1:0] SIN_ONE = (MAG_W + 2)'(1) << TRIG_FRAC_BITS;
  localparam logic [V_W-1:0] COORD_MAX_V = V_W'((64'd1 << COORD_BITS) - 64'd1);

  // Register reset values
  localparam logic [SIZE_W-1:0] NUM_ROWS_RST      = SIZE_W'(256);
  localparam logic [STEP_W-1:0] THETA_STEP_RST    = STEP_W'(128);
  localparam logic [STEP_W-1:0] PHI_STEP_RST      = STEP_W'(128);
  localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RST  = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RST = SIZE_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLUMNS   = 3'd0,
    REG_NUM_ROWS      = 3'd1,
    REG_THETA_STEP    = 3'd2,
    REG_PHI_STEP      = 3'd3,
    REG_SOURCE_WIDTH  = 3'd4,
    REG_SOURCE_HEIGHT = 3'd5
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== rtl/s2ll_if.sv =====
// Channel interfaces: pixel request in, source address out, register write.
`default_nettype none

interface s2ll_pix_if;
  logic                       valid;
  logic                       ready;
  logic [s2ll_pkg::IDX_W-1:0] column;
  logic [s2ll_pkg::IDX_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface s2ll_addr_if;
  logic                            valid;
  logic                            ready;
  logic                            from_bottom;
  logic [s2ll_pkg::COORD_BITS-1:0] src_x;
  logic [s2ll_pkg::COORD_BITS-1:0] src_y;

  modport source (output valid, output from_bottom, output src_x, output src_y, input ready);
  modport sink   (input valid, input from_bottom, input src_x, input src_y, output ready);
endinterface

interface s2ll_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [s2ll_pkg::CFG_IDX_W-1:0]  index;
  logic [s2ll_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/s2ll_sine.sv =====
// Pipelined fixed-point sine of a binary angle: quadrant fold, Horner polynomial, rounding.
`default_nettype none

module s2ll_sine (
  input  logic                                     clk_i,
  input  logic [s2ll_pkg::SIN_STAGES-1:0]          adv_i,
  input  logic [s2ll_pkg::ANGLE_BITS-1:0]          angle_i,
  output logic signed [s2ll_pkg::SIN_W-1:0]        sin_o
);

  logic [1:0]                       quad;
  logic [s2ll_pkg::ANGLE_BITS-2:0]  arg;
  logic [s2ll_pkg::QW-1:0]          z_d;
  logic [2*s2ll_pkg::QW-1:0]        zz;

  logic [s2ll_pkg::QW-1:0]          z_q   [s2ll_pkg::HORNER_N+1];
  logic                             neg_q [s2ll_pkg::HORNER_N+1];
  logic [s2ll_pkg::QW-1:0]          z2_q  [s2ll_pkg::HORNER_N];
  logic [s2ll_pkg::QW-1:0]          acc_q [s2ll_pkg::HORNER_N];

  logic [s2ll_pkg::QW-1:0]          acc_cur [s2ll_pkg::HORNER_N];
  logic [2*s2ll_pkg::QW-1:0]        hp      [s2ll_pkg::HORNER_N];
  logic [s2ll_pkg::QW:0]            diff    [s2ll_pkg::HORNER_N];

  logic [2*s2ll_pkg::QW-1:0]        sz;
  logic [s2ll_pkg::QW:0]            s_q;
  logic                             neg_s_q;

  logic [s2ll_pkg::QW+1:0]          rnd;
  logic [s2ll_pkg::MAG_W+1:0]       mag_full;
  logic [s2ll_pkg::MAG_W-1:0]       mag;
  logic signed [s2ll_pkg::SIN_W-1:0] sin_d;
  logic signed [s2ll_pkg::SIN_W-1:0] sin_q;

  // Fold into the first quadrant, scale to Q30, square
  always_comb begin
    quad = angle_i[s2ll_pkg::ANGLE_BITS-1:s2ll_pkg::ANGLE_BITS-2];
    if (quad[0]) begin
      arg = s2ll_pkg::QUARTER_R - {1'b0, angle_i[s2ll_pkg::ANGLE_BITS-3:0]};
    end else begin
      arg = {1'b0, angle_i[s2ll_pkg::ANGLE_BITS-3:0]};
    end
    z_d = s2ll_pkg::QW'(arg) << (32 - s2ll_pkg::ANGLE_BITS);
    zz  = z_d * z_d;
  end

  // One Horner step per stage
  always_comb begin
    acc_cur[0] = s2ll_pkg::ACC_INIT;
    for (int h = 1; h < s2ll_pkg::HORNER_N; h++) begin
      acc_cur[h] = acc_q[h-1];
    end
    for (int h = 0; h < s2ll_pkg::HORNER_N; h++) begin
      hp[h]   = acc_cur[h] * z2_q[h];
      diff[h] = {1'b0, s2ll_pkg::HORNER_C[h]} - hp[h][s2ll_pkg::QW+30:30];
    end
  end

  // Final multiply by z, then round half-up, cap at one and apply the sign
  always_comb begin
    sz       = acc_q[s2ll_pkg::HORNER_N-1] * z_q[s2ll_pkg::HORNER_N];
    rnd      = {1'b0, s_q} + s2ll_pkg::ROUND_ADD;
    mag_full = rnd[s2ll_pkg::QW+1:30-s2ll_pkg::TRIG_FRAC_BITS];
    if (mag_full > s2ll_pkg::SIN_ONE) begin
      mag = s2ll_pkg::SIN_ONE[s2ll_pkg::MAG_W-1:0];
    end else begin
      mag = mag_full[s2ll_pkg::MAG_W-1:0];
    end
    if (neg_s_q) begin
      sin_d = -$signed({1'b0, mag});
    end else begin
      sin_d = $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      z_q[0]   <= z_d;
      z2_q[0]  <= zz[s2ll_pkg::QW+29:30];
      neg_q[0] <= quad[1];
    end
    for (int h = 0; h < s2ll_pkg::HORNER_N; h++) begin
      if (adv_i[h+1]) begin
        acc_q[h]   <= diff[h][s2ll_pkg::QW-1:0];
        z_q[h+1]   <= z_q[h];
        neg_q[h+1] <= neg_q[h];
      end
    end
    for (int h = 0; h < s2ll_pkg::HORNER_N - 1; h++) begin
      if (adv_i[h+1]) begin
        z2_q[h+1] <= z2_q[h];
      end
    end
    if (adv_i[s2ll_pkg::HORNER_N+1]) begin
      s_q     <= sz[2*s2ll_pkg::QW-1:30];
      neg_s_q <= neg_q[s2ll_pkg::HORNER_N];
    end
    if (adv_i[s2ll_pkg::HORNER_N+2]) begin
      sin_q <= sin_d;
    end
  end

  assign sin_o = sin_q;

endmodule

`default_nettype wire

// ===== rtl/sphere_to_latlong_remap_address.sv =====
// Top level: remap address generator from lat-long map pixels to mirror-ball source pixels.
`default_nettype none

// Takes one output-map pixel (column, row) per transaction and returns which hemisphere
// image to read (from_bottom) and the clamped source pixel (src_x, src_y) in it. Theta is
// column * theta_step and phi is row * phi_step in the top half, or
// (row - num_rows/2) * phi_step less a quarter turn in the bottom half, as 16-bit binary
// angles; x = W/2 - cos(theta)sin(phi)W/2 and y = H/2 + sin(theta)sin(phi)H/2, floored and
// clamped into the source image. Rows at or past half the row count read the bottom image;
// with fewer than two rows every row does. A source size of zero acts as one. num_columns is
// accepted and kept out of the datapath, since the column count does not move any address.
// Throughput is one transaction per clock with no gaps while the output is ready. Results pass
// through registered stages: the angle multiplies, the sine pipelines (fold and square,
// five Horner steps, the final multiply, rounding), the trig product, the scale by image
// size and the floor and clamp. Each stage advances whenever it is empty or the stage after
// it advances, so bubbles close up and a stalled output holds the result while earlier
// stages keep filling. Register writes are always ready and must only be issued while no
// transaction is in flight.
module sphere_to_latlong_remap_address (
  input  logic         clk_i,
  input  logic         rst_ni,
  s2ll_pix_if.sink     pix_i,
  s2ll_addr_if.source  addr_o,
  s2ll_cfg_if.sink     cfg_i
);

  // Configuration registers
  logic [s2ll_pkg::SIZE_W-1:0] num_rows_q;
  logic [s2ll_pkg::STEP_W-1:0] theta_step_q;
  logic [s2ll_pkg::STEP_W-1:0] phi_step_q;
  logic [s2ll_pkg::SIZE_W-1:0] source_width_q;
  logic [s2ll_pkg::SIZE_W-1:0] source_height_q;

  // Pipeline control
  logic [s2ll_pkg::PIPE_STAGES-1:0] vld_q;
  logic [s2ll_pkg::PIPE_STAGES-1:0] adv;
  logic [s2ll_pkg::PIPE_STAGES-1:0] bot_q;
  logic                             in_acc;
  logic                             out_acc;

  // Angle stage
  logic [s2ll_pkg::IDX_W-1:0]          half_rows;
  logic                                bottom;
  logic [s2ll_pkg::IDX_W-1:0]          row_rel;
  logic [s2ll_pkg::IDX_W+s2ll_pkg::STEP_W-1:0] theta_full;
  logic [s2ll_pkg::IDX_W+s2ll_pkg::STEP_W-1:0] phi_full;
  logic [s2ll_pkg::ANGLE_BITS-1:0]     theta_d;
  logic [s2ll_pkg::ANGLE_BITS-1:0]     phi_d;
  logic [s2ll_pkg::ANGLE_BITS-1:0]     theta_q;
  logic [s2ll_pkg::ANGLE_BITS-1:0]     cos_ang_q;
  logic [s2ll_pkg::ANGLE_BITS-1:0]     phi_q;

  // Trig values
  logic signed [s2ll_pkg::SIN_W-1:0]   sin_theta;
  logic signed [s2ll_pkg::SIN_W-1:0]   cos_theta;
  logic signed [s2ll_pkg::SIN_W-1:0]   sin_phi;

  // Product, scale and placement stages
  logic signed [2*s2ll_pkg::SIN_W-1:0] cx_full;
  logic signed [2*s2ll_pkg::SIN_W-1:0] cx_neg;
  logic signed [2*s2ll_pkg::SIN_W-1:0] sy_full;
  logic signed [s2ll_pkg::PROD_W-1:0]  prod_x_q;
  logic signed [s2ll_pkg::PROD_W-1:0]  prod_y_q;
  logic [s2ll_pkg::SIZE_W-1:0]         eff_w;
  logic [s2ll_pkg::SIZE_W-1:0]         eff_h;
  logic signed [s2ll_pkg::PE_W-1:0]    pe_x_d;
  logic signed [s2ll_pkg::PE_W-1:0]    pe_y_d;
  logic signed [s2ll_pkg::PE_W-1:0]    pe_x_q;
  logic signed [s2ll_pkg::PE_W-1:0]    pe_y_q;
  logic [s2ll_pkg::COORD_BITS-1:0]     src_x_q;
  logic [s2ll_pkg::COORD_BITS-1:0]     src_y_q;

  // floor(floor(size/2) + pe / 2^PROD_SHIFT), clamped into the image and the coordinate range
  function automatic logic [s2ll_pkg::COORD_BITS-1:0] place(
    input logic signed [s2ll_pkg::PE_W-1:0] pe,
    input logic [s2ll_pkg::SIZE_W-1:0]      eff
  );
    logic [s2ll_pkg::NW-1:0]        half_t;
    logic signed [s2ll_pkg::NW-1:0] n;
    logic [s2ll_pkg::V_W-1:0]       v;
    logic [s2ll_pkg::V_W-1:0]       lim;
    half_t = s2ll_pkg::NW'(eff >> 1) << s2ll_pkg::PROD_SHIFT;
    n      = $signed(half_t) + s2ll_pkg::NW'(pe);
    lim    = s2ll_pkg::V_W'(eff) - s2ll_pkg::V_W'(1);
    if (n[s2ll_pkg::NW-1]) begin
      v = '0;
    end else begin
      v = n[s2ll_pkg::NW-2:s2ll_pkg::PROD_SHIFT];
      if (v > lim) begin
        v = lim;
      end
      if (v > s2ll_pkg::COORD_MAX_V) begin
        v = s2ll_pkg::COORD_MAX_V;
      end
    end
    return s2ll_pkg::COORD_BITS'(v);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Register writes: always ready, index beyond the list is dropped
  // ---------------------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q      <= s2ll_pkg::NUM_ROWS_RST;
      theta_step_q    <= s2ll_pkg::THETA_STEP_RST;
      phi_step_q      <= s2ll_pkg::PHI_STEP_RST;
      source_width_q  <= s2ll_pkg::SOURCE_WIDTH_RST;
      source_height_q <= s2ll_pkg::SOURCE_HEIGHT_RST;
    end else if (cfg_i.valid) begin
      case (s2ll_pkg::cfg_reg_e'(cfg_i.index))
        s2ll_pkg::REG_NUM_COLUMNS: begin
          // column count plays no part in addressing
        end
        s2ll_pkg::REG_NUM_ROWS:      num_rows_q      <= cfg_i.data[s2ll_pkg::SIZE_W-1:0];
        s2ll_pkg::REG_THETA_STEP:    theta_step_q    <= cfg_i.data[s2ll_pkg::STEP_W-1:0];
        s2ll_pkg::REG_PHI_STEP:      phi_step_q      <= cfg_i.data[s2ll_pkg::STEP_W-1:0];
        s2ll_pkg::REG_SOURCE_WIDTH:  source_width_q  <= cfg_i.data[s2ll_pkg::SIZE_W-1:0];
        s2ll_pkg::REG_SOURCE_HEIGHT: source_height_q <= cfg_i.data[s2ll_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage advance: a stage takes new data when it is empty or its contents move on.
  // The chain runs from the output back to the input ready.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    adv[s2ll_pkg::ST_OUT] = !vld_q[s2ll_pkg::ST_OUT] || addr_o.ready;
    for (int k = s2ll_pkg::ST_OUT - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign pix_i.ready = adv[0];
  assign in_acc      = pix_i.valid && adv[0];
  assign out_acc     = vld_q[s2ll_pkg::ST_OUT] && addr_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < s2ll_pkg::PIPE_STAGES; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Carry the hemisphere select alongside the datapath
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      bot_q[0] <= bottom;
    end
    for (int k = 1; k < s2ll_pkg::PIPE_STAGES; k++) begin
      if (adv[k]) begin
        bot_q[k] <= bot_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 0: angles. Bottom rows are taken relative to the half-way row and lose a quarter
  // turn; the cosine angle is the theta angle plus a quarter turn.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    half_rows  = s2ll_pkg::IDX_W'(num_rows_q >> 1);
    bottom     = pix_i.row >= half_rows;
    row_rel    = bottom ? (pix_i.row - half_rows) : pix_i.row;
    theta_full = pix_i.column * theta_step_q;
    phi_full   = row_rel * phi_step_q;
    theta_d    = theta_full[s2ll_pkg::ANGLE_BITS-1:0];
    phi_d      = phi_full[s2ll_pkg::ANGLE_BITS-1:0]
               - (bottom ? s2ll_pkg::QUARTER_A : '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      theta_q   <= theta_d;
      cos_ang_q <= theta_d + s2ll_pkg::QUARTER_A;
      phi_q     <= phi_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stages 1..8: three sine pipelines in lock step
  // ---------------------------------------------------------------------------------------
  s2ll_sine u_sin_theta (
    .clk_i   (clk_i),
    .adv_i   (adv[s2ll_pkg::SIN_STAGES:1]),
    .angle_i (theta_q),
    .sin_o   (sin_theta)
  );

  s2ll_sine u_cos_theta (
    .clk_i   (clk_i),
    .adv_i   (adv[s2ll_pkg::SIN_STAGES:1]),
    .angle_i (cos_ang_q),
    .sin_o   (cos_theta)
  );

  s2ll_sine u_sin_phi (
    .clk_i   (clk_i),
    .adv_i   (adv[s2ll_pkg::SIN_STAGES:1]),
    .angle_i (phi_q),
    .sin_o   (sin_phi)
  );

  // ---------------------------------------------------------------------------------------
  // Stage 9: trig products, exact at twice the fraction bits. x runs against cos.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    cx_full = cos_theta * sin_phi;
    cx_neg  = -cx_full;
    sy_full = sin_theta * sin_phi;
  end

  always_ff @(posedge clk_i) begin
    if (adv[s2ll_pkg::ST_PROD]) begin
      prod_x_q <= cx_neg[s2ll_pkg::PROD_W-1:0];
      prod_y_q <= sy_full[s2ll_pkg::PROD_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 10: scale by the image size (zero treated as one)
  // ---------------------------------------------------------------------------------------
  always_comb begin
    eff_w  = (source_width_q == '0) ? s2ll_pkg::SIZE_W'(1) : source_width_q;
    eff_h  = (source_height_q == '0) ? s2ll_pkg::SIZE_W'(1) : source_height_q;
    pe_x_d = prod_x_q * $signed({1'b0, eff_w});
    pe_y_d = prod_y_q * $signed({1'b0, eff_h});
  end

  always_ff @(posedge clk_i) begin
    if (adv[s2ll_pkg::ST_SCALE]) begin
      pe_x_q <= pe_x_d;
      pe_y_q <= pe_y_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 11: centre, floor and clamp into the output register
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv[s2ll_pkg::ST_OUT]) begin
      src_x_q <= place(pe_x_q, eff_w);
      src_y_q <= place(pe_y_q, eff_h);
    end
  end

  assign addr_o.valid       = vld_q[s2ll_pkg::ST_OUT];
  assign addr_o.from_bottom = bot_q[s2ll_pkg::ST_OUT];
  assign addr_o.src_x       = src_x_q;
  assign addr_o.src_y       = src_y_q;

`ifndef SYNTHESIS
  // Transactions in flight change only by what enters and what leaves
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(vld_q) == $past($countones(vld_q))
                       + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline occupancy does not match accepted and delivered transactions");

  // A ready output lets every stage advance, so the input is ready too
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_o.ready |-> pix_i.ready)
    else $error("input stalled although output is ready");

  a_x_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_o.valid |-> ((s2ll_pkg::SIZE_W + s2ll_pkg::COORD_BITS)'(addr_o.src_x)
                      < (s2ll_pkg::SIZE_W + s2ll_pkg::COORD_BITS)'(eff_w)))
    else $error("src_x outside the source image");

  a_y_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_o.valid |-> ((s2ll_pkg::SIZE_W + s2ll_pkg::COORD_BITS)'(addr_o.src_y)
                      < (s2ll_pkg::SIZE_W + s2ll_pkg::COORD_BITS)'(eff_h)))
    else $error("src_y outside the source image");

  a_all_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (addr_o.valid && (num_rows_q < s2ll_pkg::SIZE_W'(2))) |-> addr_o.from_bottom)
    else $error("top image selected with fewer than two rows");
`endif

endmodule

`default_nettype wire
